### src/tts_pkg.sv
// Shared constants, types and codes for the time-triggered task scheduler.
package tts_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int ACT_W  = 2;
    localparam int KIND_W = 2;
    localparam int TAG_W  = 8;
    localparam int TICK_W = 16;
    localparam int RUNS_W = 8;
    localparam int SIDX_W = 6;
    localparam int SLOT_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_DELETE   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_DISPATCH = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_RUN    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_DEL
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TICK_W-1:0] delay;
        logic [TICK_W-1:0] period;
        logic [RUNS_W-1:0] runs;
    } entry_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
        logic del;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_idx;
        logic stop;
    } dp_status_t;

endpackage

### src/time_triggered_task_scheduler.sv
// Top level of the time-triggered task scheduler.
//
//  Channel   Handshake        Word
//  request   start / busy     action, task_tag, delay_ticks, period_ticks, slot_index
//  result    strobe           result_kind, result_slot, result_tag, status_code, last
//
// Add, tick and dispatch walk the slot table one slot per cycle through the table memory's
// single read port, and busy stays high from the taking of a word until the walk has ended
// (the walk ends early when add finds an empty slot or dispatch reaches its result limit).
// Delete needs no walk. After reset every slot reads as empty at once.
// Result words appear one cycle each and cannot be stalled by the receiver.
module time_triggered_task_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [tts_pkg::TAG_W-1:0]   task_tag,
    input  logic [tts_pkg::TICK_W-1:0]  delay_ticks,
    input  logic [tts_pkg::TICK_W-1:0]  period_ticks,
    input  logic [tts_pkg::SIDX_W-1:0]  slot_index,
    output logic                        strobe,
    output logic [tts_pkg::KIND_W-1:0]  result_kind,
    output logic [tts_pkg::SLOT_W-1:0]  result_slot,
    output logic [tts_pkg::TAG_W-1:0]   result_tag,
    output logic                        status_code,
    output logic                        last
);
    import tts_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tts_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .task_tag     (task_tag),
        .delay_ticks  (delay_ticks),
        .period_ticks (period_ticks),
        .slot_index   (slot_index),
        .strobe       (strobe),
        .result_kind  (result_kind),
        .result_slot  (result_slot),
        .result_tag   (result_tag),
        .status_code  (status_code),
        .last         (last)
    );

endmodule

### src/tts_ctrl.sv
// Sequencing state machine for the task scheduler.
module tts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            action,
    input  tts_pkg::dp_status_t   status,
    output tts_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);
    import tts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (action == ACT_DELETE)
                    begin
                        state_next = ST_DEL;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                priority if (status.stop)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DEL:
            begin
                cmd.del    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/tts_dpath.sv
// Slot table, slot walk and result registers of the task scheduler.
module tts_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tts_pkg::ctrl_cmd_t          cmd,
    output tts_pkg::dp_status_t         status,
    input  logic [1:0]                  action,
    input  logic [tts_pkg::TAG_W-1:0]   task_tag,
    input  logic [tts_pkg::TICK_W-1:0]  delay_ticks,
    input  logic [tts_pkg::TICK_W-1:0]  period_ticks,
    input  logic [tts_pkg::SIDX_W-1:0]  slot_index,
    output logic                        strobe,
    output logic [tts_pkg::KIND_W-1:0]  result_kind,
    output logic [tts_pkg::SLOT_W-1:0]  result_slot,
    output logic [tts_pkg::TAG_W-1:0]   result_tag,
    output logic                        status_code,
    output logic                        last
);
    import tts_pkg::*;

    entry_t mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic                 pipe_valid_reg, pipe_valid_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 strobe_reg, strobe_next;

    action_t              action_reg;
    logic [TAG_W-1:0]     tag_in_reg;
    logic [TICK_W-1:0]    delay_in_reg;
    logic [TICK_W-1:0]    period_in_reg;
    logic [SIDX_W-1:0]    sidx_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     pipe_idx_reg;
    entry_t               rd_data_reg;
    logic                 rd_valid_reg;
    logic [SLOT_W-1:0]    add_slot_reg, add_slot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SLOT_W-1:0]    held_slot_reg, held_slot_next;
    logic [TAG_W-1:0]     held_tag_reg, held_tag_next;
    kind_t                kind_reg, kind_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic                 last_reg, last_next;

    entry_t               cur;
    entry_t               wr_data;
    logic                 wr_en;
    logic                 occupied;
    logic                 qualify;
    logic                 stop;
    logic                 del_in_range;

    // A slot that has not been written since reset or deletion reads as empty.
    assign cur      = rd_valid_reg ? rd_data_reg : '0;
    assign occupied = (cur.tag != '0);
    assign qualify  = (action_reg == ACT_DISPATCH) && occupied && (cur.runs != '0);
    assign stop     = pipe_valid_reg &&
                      (((action_reg == ACT_ADD) && !occupied) ||
                       (qualify && (cnt_reg == CNT_W'(MAX_RESULTS - 1))));
    assign del_in_range = ({1'b0, sidx_reg} < SLOT_W'(NUM_SLOTS));

    assign status.stop     = stop;
    assign status.last_idx = (idx_reg == IDX_W'(NUM_SLOTS - 1));

    always_comb
    begin
        valid_next      = valid_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_tag_next   = held_tag_reg;
        add_slot_next   = add_slot_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pipe_valid_next = 1'b0;
        wr_en           = 1'b0;
        wr_data         = cur;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        tag_next        = tag_reg;
        last_next       = last_reg;

        if (pipe_valid_reg)
        begin
            unique case (action_reg)
                ACT_ADD:
                begin
                    if (!occupied)
                    begin
                        wr_en                   = 1'b1;
                        wr_data.tag             = tag_in_reg;
                        wr_data.delay           = delay_in_reg;
                        wr_data.period          = period_in_reg;
                        wr_data.runs            = '0;
                        valid_next[pipe_idx_reg] = 1'b1;
                        add_slot_next           = SLOT_W'(pipe_idx_reg);
                    end
                end
                ACT_TICK:
                begin
                    if (occupied)
                    begin
                        wr_en = 1'b1;
                        if (cur.delay == '0)
                        begin
                            if (cur.runs != {RUNS_W{1'b1}})
                            begin
                                wr_data.runs = cur.runs + RUNS_W'(1);
                            end
                            if (cur.period != '0)
                            begin
                                wr_data.delay = cur.period - TICK_W'(1);
                            end
                        end
                        else
                        begin
                            wr_data.delay = cur.delay - TICK_W'(1);
                        end
                    end
                end
                ACT_DISPATCH:
                begin
                    if (qualify)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        // The previous run word goes out now that another one follows it.
                        if (held_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            kind_next   = KIND_RUN;
                            slot_next   = held_slot_reg;
                            tag_next    = held_tag_reg;
                            last_next   = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_slot_next  = SLOT_W'(pipe_idx_reg);
                        held_tag_next   = cur.tag;
                        if (cur.period == '0)
                        begin
                            valid_next[pipe_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            wr_data.runs = cur.runs - RUNS_W'(1);
                        end
                    end
                end
                ACT_DELETE:
                begin
                end
            endcase
        end

        if (cmd.issue)
        begin
            idx_next        = idx_reg + IDX_W'(1);
            pipe_valid_next = !stop;
        end

        if (cmd.load)
        begin
            idx_next        = '0;
            cnt_next        = '0;
            held_valid_next = 1'b0;
            add_slot_next   = SLOT_W'(NUM_SLOTS);
        end

        if (cmd.finish)
        begin
            if (action_reg == ACT_ADD)
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_ADD;
                slot_next   = add_slot_reg;
                tag_next    = '0;
                last_next   = 1'b1;
            end
            else if ((action_reg == ACT_DISPATCH) && held_valid_reg)
            begin
                strobe_next     = 1'b1;
                kind_next       = KIND_RUN;
                slot_next       = held_slot_reg;
                tag_next        = held_tag_reg;
                last_next       = 1'b1;
                held_valid_next = 1'b0;
            end
        end

        if (cmd.del)
        begin
            if (del_in_range)
            begin
                valid_next[sidx_reg[IDX_W-1:0]] = 1'b0;
            end
            strobe_next = 1'b1;
            kind_next   = KIND_DELETE;
            slot_next   = {1'b0, sidx_reg};
            tag_next    = '0;
            last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pipe_idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            pipe_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            pipe_valid_reg <= pipe_valid_next;
            held_valid_reg <= held_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg    <= action_t'(action);
            tag_in_reg    <= task_tag;
            delay_in_reg  <= delay_ticks;
            period_in_reg <= period_ticks;
            sidx_reg      <= slot_index;
        end
        rd_valid_reg  <= valid_reg[idx_reg];
        pipe_idx_reg  <= idx_reg;
        idx_reg       <= idx_next;
        add_slot_reg  <= add_slot_next;
        cnt_reg       <= cnt_next;
        held_slot_reg <= held_slot_next;
        held_tag_reg  <= held_tag_next;
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        tag_reg       <= tag_next;
        last_reg      <= last_next;
    end

    assign strobe      = strobe_reg;
    assign result_kind = kind_reg;
    assign result_slot = slot_reg;
    assign result_tag  = tag_reg;
    assign status_code = 1'b0;
    assign last        = last_reg;

endmodule
